/* rtl/core/client_traffic_table_unit_defines.svh */
// assertion macros for the client traffic table
`ifndef CLIENT_TRAFFIC_TABLE_UNIT_DEFINES_SVH
`define CLIENT_TRAFFIC_TABLE_UNIT_DEFINES_SVH

// implication checked on every rising clock edge outside reset
`define CTT_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication checked outside reset
`define CTT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* rtl/core/ctt_pkg.sv */
// ---------------------------------------------------------------------------
// ctt_pkg
// types and constants shared by the client traffic table
// ---------------------------------------------------------------------------
package ctt_pkg;

    localparam logic [1:0] CMD_UP     = 2'd0;
    localparam logic [1:0] CMD_DOWN   = 2'd1;
    localparam logic [1:0] CMD_RATE   = 2'd2;
    localparam logic [1:0] CMD_EXPIRE = 2'd3;

    localparam logic [2:0] ST_HIT      = 3'd0;
    localparam logic [2:0] ST_ADDED    = 3'd1;
    localparam logic [2:0] ST_FULL     = 3'd2;
    localparam logic [2:0] ST_NOTFOUND = 3'd3;
    localparam logic [2:0] ST_EXPIRED  = 3'd4;
    localparam logic [2:0] ST_NONE     = 3'd5;
    localparam logic [2:0] ST_EMPTY    = 3'd6;

    localparam logic [1:0] REG_ACT_THR  = 2'd0;
    localparam logic [1:0] REG_INACT    = 2'd1;
    localparam logic [1:0] REG_MAX_IDLE = 2'd2;

    localparam logic [15:0] ACT_THR_RESET  = 16'd20;
    localparam logic [15:0] INACT_RESET    = 16'd30;
    localparam logic [31:0] MAX_IDLE_RESET = 32'd300;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [47:0] mac;
        logic [31:0] ip_addr;
        logic [15:0] pkt_length;
        logic [5:0]  slot_sel;
        logic [31:0] now_seconds;
    } t_ctt_in;

    typedef struct packed {
        logic [2:0]  status;
        logic [5:0]  slot;
        logic [47:0] removed_mac;
        logic [31:0] up_rate;
        logic [31:0] dn_rate;
        logic [31:0] up_frame_rate;
        logic [31:0] dn_frame_rate;
        logic        active;
    } t_ctt_out;

    // per-slot record held in the table memory
    typedef struct packed {
        logic [47:0] mac;
        logic [31:0] ip;
        logic [63:0] up_octets;
        logic [63:0] dn_octets;
        logic [31:0] up_frames;
        logic [31:0] dn_frames;
        logic [63:0] last_up_octets;
        logic [63:0] last_dn_octets;
        logic [31:0] last_up_frames;
        logic [31:0] last_dn_frames;
        logic [31:0] active_run;
        logic [31:0] inactive_run;
        logic        active_flag;
        logic [31:0] last_seen;
    } t_ctt_entry;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_FREE,
        S_READ,
        S_WAIT,
        S_UPD,
        S_RATE1,
        S_RATE2,
        S_DONE
    } t_ctt_state;

endpackage

/* rtl/core/client_traffic_table_unit.sv */
// ---------------------------------------------------------------------------
// client_traffic_table_unit
// per-client traffic accounting table keyed by MAC address
// ---------------------------------------------------------------------------
// A command is taken when i_start is high and o_busy is low. The block then
// stays busy and presents one result on o_result for one cycle with
// o_done high; the receiver cannot stall it. The next command may be taken
// in the cycle that carries o_done.
// Upstream, downstream and expiry commands scan the table one slot a cycle
// through a single registered-read memory port and one shared compare: a
// scan of the table, a second scan of the valid bits for a free slot when an
// upstream MAC misses, then read; upstream and downstream update and write
// back, while expiry clears the valid bit. A rate update reads one slot; an
// empty slot answers without a read.
// Reset clears the valid bits and loads the register defaults; no clearing
// pass runs. Config writes on i_cfg_we land at once and are meant for idle
// periods only.
// ---------------------------------------------------------------------------
module client_traffic_table_unit
    import ctt_pkg::*;
#(
    parameter int ENTRIES = 64
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  t_ctt_in         i_cmd,
    output logic            o_busy,
    output logic            o_done,
    output t_ctt_out        o_result,
    input  logic            i_cfg_we,
    input  logic [1:0]      i_cfg_index,
    input  logic [31:0]     i_cfg_data
);

    localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = AW + 1;

    t_ctt_entry r_mem [ENTRIES];
    t_ctt_entry r_rd;
    logic [ENTRIES-1:0] r_valid;

    logic [15:0] r_act_thr;
    logic [15:0] r_inact;
    logic [31:0] r_max_idle;

    t_ctt_state r_state, n_state;
    t_ctt_in    r_in;
    logic [CW-1:0] r_idx, n_idx;
    logic [AW-1:0] r_slot, n_slot;
    logic          r_found, n_found;
    logic          r_added, n_added;
    t_ctt_out      r_out, n_out;
    logic          r_done, n_done;
    t_ctt_entry    r_wr, n_wr;
    logic          r_we, n_we;
    logic [31:0]   r_pdr, n_pdr;

    // memory read address and compare
    logic [AW-1:0] rd_addr;
    logic          cmp_hit;
    logic [32:0]   deadline;

    // config register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act_thr  <= ACT_THR_RESET;
            r_inact    <= INACT_RESET;
            r_max_idle <= MAX_IDLE_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_ACT_THR:  r_act_thr  <= i_cfg_data[15:0];
                REG_INACT:    r_inact    <= i_cfg_data[15:0];
                REG_MAX_IDLE: r_max_idle <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // table memory: one write port, one registered read
    always_comb begin
        rd_addr = r_idx[AW-1:0];
        if (r_state == S_READ || r_state == S_WAIT || r_state == S_UPD)
            rd_addr = r_slot;
    end

    always_ff @(posedge i_clk) begin
        if (r_we)
            r_mem[r_slot] <= r_wr;
        r_rd <= r_mem[rd_addr];
    end

    // the entry in r_rd belongs to index r_idx-1 during the scan
    always_comb begin
        deadline = {1'b0, r_rd.last_seen} + {1'b0, r_max_idle};
        case (r_in.cmd)
            CMD_UP:   cmp_hit = (r_rd.mac == r_in.mac);
            CMD_DOWN: cmp_hit = (r_rd.ip == r_in.ip_addr);
            default:  cmp_hit = ({1'b0, r_in.now_seconds} > deadline);
        endcase
    end

    // sequencer registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
            r_we    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
            r_we    <= n_we;
        end
        r_idx    <= n_idx;
        r_slot   <= n_slot;
        r_found  <= n_found;
        r_added  <= n_added;
        r_out    <= n_out;
        r_wr     <= n_wr;
        r_pdr    <= n_pdr;
        if (i_start && !o_busy)
            r_in <= i_cmd;
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_valid <= '0;
        else if (r_state == S_UPD && r_found && r_in.cmd == CMD_EXPIRE)
            r_valid[r_slot] <= 1'b0;
        else if (r_state == S_UPD && r_added)
            r_valid[r_slot] <= 1'b1;
    end

    // next state and datapath
    always_comb begin
        logic [63:0] d64;
        logic [63:0] h64;
        n_state  = r_state;
        n_idx    = r_idx;
        n_slot   = r_slot;
        n_found  = r_found;
        n_added  = r_added;
        n_out    = r_out;
        n_done   = 1'b0;
        n_wr     = r_wr;
        n_we     = 1'b0;
        n_pdr    = r_pdr;
        d64      = '0;
        h64      = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_idx   = '0;
                    n_found = 1'b0;
                    n_added = 1'b0;
                    n_out   = '0;
                    if (i_cmd.cmd == CMD_RATE) begin
                        n_out.slot = i_cmd.slot_sel;
                        if ({26'd0, i_cmd.slot_sel} >= 32'(ENTRIES) ||
                            !r_valid[AW'(i_cmd.slot_sel)]) begin
                            n_out.status = ST_EMPTY;
                            n_state = S_DONE;
                        end else begin
                            n_slot  = AW'(i_cmd.slot_sel);
                            n_state = S_READ;
                        end
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            // one slot per cycle; r_rd holds slot r_idx-1
            S_SCAN: begin
                if (r_idx != '0 && r_valid[r_slot] && cmp_hit) begin
                    n_found = 1'b1;
                    n_state = S_READ;
                end else if (r_idx == CW'(ENTRIES)) begin
                    if (r_in.cmd == CMD_UP) begin
                        n_idx   = '0;
                        n_state = S_FREE;
                    end else begin
                        n_out.status = (r_in.cmd == CMD_DOWN) ? ST_NOTFOUND : ST_NONE;
                        n_state = S_DONE;
                    end
                end else begin
                    n_slot = r_idx[AW-1:0];
                    n_idx  = r_idx + 1'b1;
                end
            end
            // lowest free slot, one valid bit per cycle
            S_FREE: begin
                if (r_idx == CW'(ENTRIES)) begin
                    n_out.status = ST_FULL;
                    n_state = S_DONE;
                end else if (!r_valid[r_idx[AW-1:0]]) begin
                    n_slot  = r_idx[AW-1:0];
                    n_added = 1'b1;
                    n_state = S_READ;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_READ: n_state = S_WAIT;
            S_WAIT: n_state = S_UPD;
            S_UPD: begin
                n_wr = r_rd;
                n_out.slot = 6'(r_slot);
                case (r_in.cmd)
                    CMD_UP: begin
                        if (r_added) begin
                            n_wr = '0;
                            n_wr.mac = r_in.mac;
                            n_out.status = ST_ADDED;
                        end else begin
                            n_out.status = ST_HIT;
                        end
                        n_wr.ip        = r_in.ip_addr;
                        n_wr.up_octets = n_wr.up_octets + 64'(r_in.pkt_length);
                        n_wr.up_frames = n_wr.up_frames + 32'd1;
                        n_wr.last_seen = r_in.now_seconds;
                        n_we    = 1'b1;
                        n_state = S_DONE;
                    end
                    CMD_DOWN: begin
                        n_wr.dn_octets = r_rd.dn_octets + 64'(r_in.pkt_length);
                        n_wr.dn_frames = r_rd.dn_frames + 32'd1;
                        n_out.status = ST_HIT;
                        n_we    = 1'b1;
                        n_state = S_DONE;
                    end
                    CMD_RATE: begin
                        d64 = r_rd.up_octets - r_rd.last_up_octets;
                        h64 = d64 >> 1;
                        n_out.up_rate = (h64[63:32] != '0) ? '1 : h64[31:0];
                        n_out.up_frame_rate = (r_rd.up_frames - r_rd.last_up_frames) >> 1;
                        n_wr.last_up_octets = r_rd.up_octets;
                        n_wr.last_up_frames = r_rd.up_frames;
                        n_state = S_RATE1;
                    end
                    default: begin
                        n_out.status      = ST_EXPIRED;
                        n_out.removed_mac = r_rd.mac;
                        n_state = S_DONE;
                    end
                endcase
            end
            S_RATE1: begin
                d64 = r_wr.dn_octets - r_wr.last_dn_octets;
                h64 = d64 >> 1;
                n_out.dn_rate = (h64[63:32] != '0) ? '1 : h64[31:0];
                n_pdr = (r_wr.dn_frames - r_wr.last_dn_frames) >> 1;
                n_out.dn_frame_rate = n_pdr;
                n_wr.last_dn_octets = r_wr.dn_octets;
                n_wr.last_dn_frames = r_wr.dn_frames;
                n_state = S_RATE2;
            end
            S_RATE2: begin
                if (r_pdr > {16'd0, r_act_thr}) begin
                    if (r_wr.active_run != '1)
                        n_wr.active_run = r_wr.active_run + 32'd1;
                    n_wr.inactive_run = '0;
                    n_wr.active_flag  = 1'b1;
                end else begin
                    if (r_wr.inactive_run != '1)
                        n_wr.inactive_run = r_wr.inactive_run + 32'd1;
                    n_wr.active_run = '0;
                    if (r_wr.active_flag && n_wr.inactive_run > {16'd0, r_inact})
                        n_wr.active_flag = 1'b0;
                end
                n_out.active = n_wr.active_flag;
                n_out.status = ST_HIT;
                n_we    = 1'b1;
                n_state = S_DONE;
            end
            S_DONE: begin
                n_done  = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_busy   = (r_state != S_IDLE);
    assign o_done   = r_done;
    assign o_result = r_out;

endmodule

/* rtl/core/ctt_checker.sv */
// ---------------------------------------------------------------------------
// ctt_checker
// port-level checks on the client traffic table
// ---------------------------------------------------------------------------
`include "client_traffic_table_unit_defines.svh"

module ctt_checker
    import ctt_pkg::*;
(
    input logic     i_clk,
    input logic     i_rst_n,
    input logic     i_start,
    input logic     o_busy,
    input logic     o_done,
    input t_ctt_out o_result
);

    // an accepted command makes the block busy
    `CTT_ASSERT_NEXT(a_start_busy, i_clk, i_rst_n, i_start && !o_busy, o_busy)
    // a result strobe lasts one cycle
    `CTT_ASSERT_NEXT(a_done_pulse, i_clk, i_rst_n, o_done, !o_done)
    // status codes stay in range
    `CTT_ASSERT_IMPL(a_status, i_clk, i_rst_n, o_done, o_result.status != 3'd7)
    // only expiry reports a removed mac
    `CTT_ASSERT_IMPL(a_mac, i_clk, i_rst_n, o_done && o_result.status != ST_EXPIRED,
        o_result.removed_mac == '0)

endmodule

bind client_traffic_table_unit ctt_checker u_ctt_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_start  (i_start),
    .o_busy   (o_busy),
    .o_done   (o_done),
    .o_result (o_result)
);
